[sv/lped_pkg.sv]
// package for the length-prefixed element deframer
// holds widths, character codes, phase/role/error codes and the state/result structs
// no dependencies
package lped_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int INDEX_WIDTH  = 8;
  localparam int ACC_WIDTH    = LENGTH_WIDTH + 1;
  localparam int MAXLEN_WIDTH = 16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  localparam logic [MAXLEN_WIDTH-1:0] MAXLEN_RESET = '1;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_ELEM = 2'd1,
    PH_SEP  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_DIGIT   = 3'd0,
    ROLE_DOT     = 3'd1,
    ROLE_CONTENT = 3'd2,
    ROLE_COMMA   = 3'd3,
    ROLE_SEMI    = 3'd4
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY_LEN = 3'd1,
    ERR_BAD_CHAR  = 3'd2,
    ERR_TOO_LARGE = 3'd3,
    ERR_BAD_SEP   = 3'd4,
    ERR_EMPTY_OP  = 3'd5
  } err_e;

  typedef struct packed {
    phase_e                  phase;
    logic [ACC_WIDTH-1:0]    acc;
    logic                    digit_seen;
    logic [LENGTH_WIDTH-1:0] decl_len;
    logic [LENGTH_WIDTH-1:0] cnt;
    logic [INDEX_WIDTH-1:0]  elem_cnt;
    logic                    op_seen;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      PH_LEN,
    acc:        '0,
    digit_seen: 1'b0,
    decl_len:   '0,
    cnt:        '0,
    elem_cnt:   '0,
    op_seen:    1'b0
  };

  typedef struct packed {
    logic [7:0]              data_byte;
    role_e                   role;
    logic [INDEX_WIDTH-1:0]  elem_num;
    logic                    is_op;
    logic [LENGTH_WIDTH-1:0] size;
    logic                    edone;
    logic                    idone;
    err_e                    err;
  } result_t;

endpackage

[sv/length_prefixed_element_deframer_unit.sv]
// Parses a byte stream of LEN.VALUE[,LEN.VALUE]...; instructions and tags every byte with
// its role, element index, declared size and an error code. One byte is taken per clock
// cycle; each byte's result appears in the cycle after its transfer, set by the single parser
// state register feeding the result register. The input stays ready while the result
// register is empty or being drained, so full throughput holds with tready high. Any error
// restarts the parser at instruction start. max_element_length is written via cfg_wr_en_i.
// depends on lped_pkg and lped_step
module length_prefixed_element_deframer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [lped_pkg::MAXLEN_WIDTH-1:0] cfg_wr_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] byte_value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] data_byte, [15:8] element_number, [31:16] element_size,
  // [32] element_done, [35:33] error_code, [39:36] zero
  output logic [39:0]                       m_axis_tdata,
  output logic [3:0]                        m_axis_tuser,  // [2:0] byte_role, [3] is_opcode
  output logic                              m_axis_tlast   // instruction_done
);
  import lped_pkg::*;

  state_t                    state_q, state_d;
  result_t                   res_q, res_d;
  logic                      out_valid_q;
  logic [MAXLEN_WIDTH-1:0]   max_len_q;
  logic                      in_xfer;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  lped_step u_step (
    .st_i      (state_q),
    .byte_i    (s_axis_tdata),
    .max_len_i (max_len_q),
    .st_o      (state_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RESET;
      out_valid_q <= 1'b0;
      max_len_q   <= MAXLEN_RESET;
    end else begin
      if (cfg_wr_en_i) begin
        max_len_q <= cfg_wr_data_i;
      end
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.err, res_q.edone, res_q.size,
                          res_q.elem_num, res_q.data_byte};
  assign m_axis_tuser  = {res_q.is_op, res_q.role};
  assign m_axis_tlast  = res_q.idone;

  // errored bytes never complete an element or instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.err != ERR_NONE) |-> (!res_q.edone && !res_q.idone))
    else $error("done flag on errored byte");

  // instruction end only on a semicolon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.idone) |-> (res_q.role == ROLE_SEMI))
    else $error("instruction done without semicolon");

  // an error restarts the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_d.err != ERR_NONE) |=>
      (state_q.phase == PH_LEN && state_q.elem_cnt == '0 && !state_q.op_seen))
    else $error("no restart after error");

  // a completed instruction clears the element index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_d.idone) |=> (state_q.elem_cnt == '0 && !state_q.op_seen))
    else $error("element index kept after instruction end");

  // element completion only on separators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.edone) |->
      (res_q.role == ROLE_COMMA || res_q.role == ROLE_SEMI))
    else $error("element done without separator");

endmodule

[sv/lped_step.sv]
// per-byte parser step: next state and tagged result for one input byte
// depends on lped_pkg
module lped_step (
  input  lped_pkg::state_t                    st_i,
  input  logic [7:0]                          byte_i,
  input  logic [lped_pkg::MAXLEN_WIDTH-1:0]   max_len_i,
  output lped_pkg::state_t                    st_o,
  output lped_pkg::result_t                   res_o
);
  import lped_pkg::*;

  localparam int MulWidth = ACC_WIDTH + 4;
  localparam logic [MulWidth-1:0] AccMax = MulWidth'({ACC_WIDTH{1'b1}});

  logic                    is_digit;
  logic [7:0]              digit;
  logic [MulWidth-1:0]     acc_ext;
  logic [MulWidth-1:0]     acc_mul;
  logic [LENGTH_WIDTH-1:0] cnt_inc;
  logic                    too_large;

  assign is_digit  = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign digit     = byte_i - CH_0;
  assign acc_ext   = MulWidth'(st_i.acc);
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + MulWidth'(digit[3:0]);
  assign cnt_inc   = st_i.cnt + LENGTH_WIDTH'(1);
  assign too_large = (MulWidth'(st_i.acc) > MulWidth'(max_len_i)) || st_i.acc[LENGTH_WIDTH];

  always_comb begin
    st_o            = st_i;
    res_o.data_byte = byte_i;
    res_o.role      = ROLE_DIGIT;
    res_o.elem_num  = st_i.elem_cnt;
    res_o.is_op     = !st_i.op_seen;
    res_o.size      = '0;
    res_o.edone     = 1'b0;
    res_o.idone     = 1'b0;
    res_o.err       = ERR_NONE;

    case (st_i.phase)
      PH_LEN: begin
        if (is_digit) begin
          st_o.acc        = (acc_mul > AccMax) ? {ACC_WIDTH{1'b1}} : acc_mul[ACC_WIDTH-1:0];
          st_o.digit_seen = 1'b1;
        end else if (byte_i == CH_DOT) begin
          res_o.role = ROLE_DOT;
          if (!st_i.digit_seen) begin
            res_o.err = ERR_EMPTY_LEN;
          end else if (too_large) begin
            res_o.err = ERR_TOO_LARGE;
          end else begin
            st_o.decl_len   = st_i.acc[LENGTH_WIDTH-1:0];
            res_o.size      = st_i.acc[LENGTH_WIDTH-1:0];
            st_o.acc        = '0;
            st_o.digit_seen = 1'b0;
            st_o.cnt        = '0;
            st_o.phase      = (st_i.acc[LENGTH_WIDTH-1:0] == '0) ? PH_SEP : PH_ELEM;
          end
        end else begin
          res_o.err = ERR_BAD_CHAR;
        end
      end
      PH_ELEM: begin
        res_o.role = ROLE_CONTENT;
        res_o.size = st_i.decl_len;
        st_o.cnt   = cnt_inc;
        if (cnt_inc == st_i.decl_len) begin
          st_o.phase = PH_SEP;
        end
      end
      default: begin
        res_o.size = st_i.decl_len;
        if (byte_i == CH_COMMA || byte_i == CH_SEMI) begin
          res_o.role  = (byte_i == CH_COMMA) ? ROLE_COMMA : ROLE_SEMI;
          res_o.is_op = 1'b0;
          if (!st_i.op_seen) begin
            if (st_i.decl_len != '0) begin
              st_o.op_seen = 1'b1;
              res_o.is_op  = 1'b1;
              res_o.edone  = 1'b1;
            end
          end else begin
            res_o.edone = 1'b1;
          end
          if (res_o.edone && st_i.elem_cnt != '1) begin
            st_o.elem_cnt = st_i.elem_cnt + INDEX_WIDTH'(1);
          end
          st_o.phase = PH_LEN;
          st_o.cnt   = '0;
          if (byte_i == CH_SEMI) begin
            if (!st_o.op_seen) begin
              res_o.err = ERR_EMPTY_OP;
            end else begin
              res_o.idone   = 1'b1;
              st_o.elem_cnt = '0;
              st_o.op_seen  = 1'b0;
            end
          end
        end else begin
          res_o.role = ROLE_COMMA;
          res_o.err  = ERR_BAD_SEP;
        end
      end
    endcase

    if (res_o.err != ERR_NONE) begin
      res_o.edone = 1'b0;
      res_o.idone = 1'b0;
      st_o        = ST_RESET;
    end
  end

endmodule
